// ===== rtl/core/rrr_pkg.sv =====
`timescale 1ns / 1ps

package rrr_pkg;

    localparam int SIDE_DEF  = 256;
    localparam int Q14_HALF  = 8192;
    localparam int TRIG_W    = 16;
    localparam int ROM_LAST  = 90;

    // Divisors (2n)(2n+1) of the Taylor terms, n = 1..8.
    localparam logic [8:1][63:0] TAYLOR_DIV = {
        64'd272, 64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
    };

    typedef logic [ROM_LAST:0][TRIG_W-1:0] sine_table_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRIG,
        ST_MUL,
        ST_ROW,
        ST_WALK,
        ST_READ
    } state_t;

    // Commands from the sequencer to the point unit.
    typedef struct packed {
        logic load_trig;
        logic load_mul;
        logic load_row;
        logic col_step;
        logic row_step;
    } pu_cmd_t;

    // Quarter-wave sine in Q2.14, round-half-up of a Q30 Taylor series.
    function automatic sine_table_t build_sine();
        sine_table_t tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rnd;
        tbl = '0;
        for (int k = 0; k <= ROM_LAST; k++) begin
            x    = (64'(k) * 64'd3373259426 + 64'd90) / 64'd180;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if ((n % 2) == 1) begin
                    sum = sum - term;
                end
                else begin
                    sum = sum + term;
                end
            end
            rnd    = (sum + 64'd32768) >> 16;
            tbl[k] = rnd[TRIG_W-1:0];
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_ROM = build_sine();

    // Full-circle sine for an angle already reduced below 360.
    function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [8:0] a);
        logic [8:0] m;
        logic       neg;
        if (a < 9'd90) begin
            m   = a;
            neg = 1'b0;
        end
        else if (a < 9'd180) begin
            m   = 9'd180 - a;
            neg = 1'b0;
        end
        else if (a < 9'd270) begin
            m   = a - 9'd180;
            neg = 1'b1;
        end
        else begin
            m   = 9'd360 - a;
            neg = 1'b1;
        end
        return neg ? -$signed(SINE_ROM[m[6:0]]) : $signed(SINE_ROM[m[6:0]]);
    endfunction

endpackage

// ===== rtl/core/rrr_ram.sv =====
`timescale 1ns / 1ps

module rrr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rrr_point_unit.sv =====
`timescale 1ns / 1ps

module rrr_point_unit #(
    parameter int SIDE = rrr_pkg::SIDE_DEF
) (
    input  logic                    clk,
    input  logic [8:0]              angle,
    input  logic [3:0]              half,
    input  logic [7:0]              radius,
    input  rrr_pkg::pu_cmd_t        cmd,
    output logic [$clog2(SIDE)-1:0] pix_x,
    output logic [$clog2(SIDE)-1:0] pix_y,
    output logic                    on_canvas
);

    import rrr_pkg::*;

    localparam int CW     = $clog2(SIDE);
    localparam int POS_W  = ((CW > 8) ? CW : 8) + 16;
    localparam int XI_W   = POS_W - 14;
    localparam int MUL_W  = 9 + TRIG_W;
    localparam logic signed [POS_W-1:0] CENTRE = POS_W'(SIDE * Q14_HALF);
    localparam logic signed [POS_W-1:0] HALF_Q = POS_W'(Q14_HALF);
    localparam logic signed [XI_W-1:0]  SIDE_S = XI_W'(SIDE);

    logic signed [TRIG_W-1:0] sa_reg, ca_reg;
    logic signed [POS_W-1:0]  m_rs_reg, m_hc_reg, m_rc_reg, m_hs_reg;
    logic signed [POS_W-1:0]  row_x_reg, row_y_reg, cur_x_reg, cur_y_reg;

    logic [8:0]               a_red, b_sum, b_red;
    logic signed [MUL_W-1:0]  p_rs, p_hc, p_rc, p_hs;
    logic signed [POS_W-1:0]  sa_ext, ca_ext;
    logic signed [POS_W-1:0]  nrow_x, nrow_y;
    logic signed [POS_W-1:0]  rnd_x, rnd_y;
    logic signed [XI_W-1:0]   xi, yi;

    always_comb
    begin
        a_red = (angle >= 9'd360) ? angle - 9'd360 : angle;
        b_sum = a_red + 9'd90;
        b_red = (b_sum >= 9'd360) ? b_sum - 9'd360 : b_sum;
    end

    assign p_rs = $signed({1'b0, radius}) * sa_reg;
    assign p_rc = $signed({1'b0, radius}) * ca_reg;
    assign p_hc = $signed({5'b0, half}) * ca_reg;
    assign p_hs = $signed({5'b0, half}) * sa_reg;

    assign sa_ext = POS_W'(sa_reg);
    assign ca_ext = POS_W'(ca_reg);

    // Row start: the row seed for init, else move one row inward.
    always_comb
    begin
        if (cmd.load_row)
        begin
            nrow_x = CENTRE + m_rs_reg - m_hc_reg;
            nrow_y = CENTRE - m_hs_reg - m_rc_reg;
        end
        else
        begin
            nrow_x = row_x_reg - sa_ext;
            nrow_y = row_y_reg + ca_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_trig)
        begin
            sa_reg <= sin_q14(a_red);
            ca_reg <= sin_q14(b_red);
        end
        if (cmd.load_mul)
        begin
            m_rs_reg <= POS_W'(p_rs);
            m_hc_reg <= POS_W'(p_hc);
            m_rc_reg <= POS_W'(p_rc);
            m_hs_reg <= POS_W'(p_hs);
        end
        if (cmd.load_row || cmd.row_step)
        begin
            row_x_reg <= nrow_x;
            row_y_reg <= nrow_y;
            cur_x_reg <= nrow_x;
            cur_y_reg <= nrow_y;
        end
        else if (cmd.col_step)
        begin
            cur_x_reg <= cur_x_reg + ca_ext;
            cur_y_reg <= cur_y_reg + sa_ext;
        end
    end

    // Round half up: arithmetic shift gives a true floor.
    assign rnd_x = cur_x_reg + HALF_Q;
    assign rnd_y = cur_y_reg + HALF_Q;
    assign xi    = rnd_x[POS_W-1:14];
    assign yi    = rnd_y[POS_W-1:14];

    assign on_canvas = !xi[XI_W-1] && !yi[XI_W-1] && (xi < SIDE_S) && (yi < SIDE_S);
    assign pix_x     = xi[CW-1:0];
    assign pix_y     = yi[CW-1:0];

endmodule

// ===== rtl/core/rotated_rect_rasterizer.sv =====
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// in        in_valid / in_stall  action angle_deg rect_width rect_length
//                                outer_radius paint_colour read_x read_y
// out       out_valid/ out_stall pixel_value
//
// After reset a clearing pass writes zero to every canvas entry, with
// in_stall held high. A paint beat passes setup states trig, multiply and
// row seed, then walks rect_length*(2*(rect_width/2)+1) points, one canvas
// write port access per point; zero length skips both.
// A read beat goes through the registered canvas read port, then the read state.
// in_stall is high while a beat is in work or a read result waits on out.

module rotated_rect_rasterizer #(
    parameter int SIDE = rrr_pkg::SIDE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [8:0]  angle_deg,
    input  logic [4:0]  rect_width,
    input  logic [7:0]  rect_length,
    input  logic [7:0]  outer_radius,
    input  logic [15:0] paint_colour,
    input  logic [7:0]  read_x,
    input  logic [7:0]  read_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pixel_value
);

    import rrr_pkg::*;

    localparam int CW     = $clog2(SIDE);
    localparam int DEPTH  = SIDE * SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] SIDE_A    = ADDR_W'(SIDE);
    localparam logic [9:0]        SIDE_R    = 10'(SIDE);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [8:0]        angle_reg;
    logic [3:0]        half_reg;
    logic [7:0]        radius_reg;
    logic [7:0]        last_row_reg;
    logic [15:0]       colour_reg;
    logic [7:0]        row_reg, row_next;
    logic [4:0]        col_reg, col_next;
    logic              in_range_reg;
    logic              out_valid_reg;
    logic [15:0]       pixel_reg;

    logic              in_accept;
    logic              col_end, row_end;
    logic              read_ok;
    pu_cmd_t           cmd;

    logic [CW-1:0]     pix_x, pix_y;
    logic              on_canvas;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [15:0]       ram_wdata, ram_rdata;

    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign col_end   = (col_reg == {half_reg, 1'b0});
    assign row_end   = (row_reg == last_row_reg);
    assign read_ok   = ({2'b0, read_x} < SIDE_R) && ({2'b0, read_y} < SIDE_R);

    // Sequencer: clearing pass, setup chain, point walk, read turnaround.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (action)
                    begin
                        state_next = ST_READ;
                    end
                    else if (rect_length != 8'd0)
                    begin
                        state_next = ST_TRIG;
                    end
                end
            end
            ST_TRIG:
            begin
                cmd.load_trig = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.load_mul = 1'b1;
                state_next   = ST_ROW;
            end
            ST_ROW:
            begin
                cmd.load_row = 1'b1;
                row_next     = '0;
                col_next     = '0;
                state_next   = ST_WALK;
            end
            ST_WALK:
            begin
                if (!col_end)
                begin
                    cmd.col_step = 1'b1;
                    col_next     = col_reg + 1'b1;
                end
                else if (!row_end)
                begin
                    cmd.row_step = 1'b1;
                    col_next     = '0;
                    row_next     = row_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (state_reg == ST_READ)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Beat payload: hold for the length of the paint or read.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            angle_reg    <= angle_deg;
            half_reg     <= rect_width[4:1];
            radius_reg   <= outer_radius;
            last_row_reg <= rect_length - 8'd1;
            colour_reg   <= paint_colour;
            in_range_reg <= read_ok;
        end
        if (state_reg == ST_READ)
        begin
            pixel_reg <= in_range_reg ? ram_rdata : 16'd0;
        end
    end

    rrr_point_unit #(
        .SIDE (SIDE)
    ) u_point (
        .clk       (clk),
        .angle     (angle_reg),
        .half      (half_reg),
        .radius    (radius_reg),
        .cmd       (cmd),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .on_canvas (on_canvas)
    );

    // Canvas write port: clearing pass, then covered points; drop the rest.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = (state_reg == ST_WALK) && on_canvas;
            ram_waddr = ADDR_W'(ADDR_W'(pix_y) * SIDE_A + ADDR_W'(pix_x));
            ram_wdata = colour_reg;
        end
    end

    // Read address straight from the beat; data lands in the read state.
    assign ram_raddr = ADDR_W'(ADDR_W'(read_y) * SIDE_A + ADDR_W'(read_x));

    rrr_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_canvas (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_reg;

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_WALK))
        else $error("canvas write outside clear or walk");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_READ))
        else $error("result raised without a read");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && col_end && row_end) |=> (state_reg == ST_IDLE))
        else $error("walk did not end after last point");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !$past(in_accept))
        else $error("beat accepted during clearing pass");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int SIDE = rrr_pkg::SIDE_DEF;
    localparam int HALF_Q14 = rrr_pkg::Q14_HALF;
    localparam longint CENTRE_Q14 = longint'(SIDE) * HALF_Q14;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    // The clearing pass alone idles the channels while it writes every canvas
    // entry; the largest paint walks 255 rows of 31 points. Leave plenty of room above.
    localparam int STUCK_LIMIT = 300000;
    localparam int RANDOM_BEATS = 1850;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic [15:0] pixel;
        int          x;
        int          y;
    } readback_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = 1'b0;
    logic [8:0]  angle_deg = '0;
    logic [4:0]  rect_width = '0;
    logic [7:0]  rect_length = '0;
    logic [7:0]  outer_radius = '0;
    logic [15:0] paint_colour = '0;
    logic [7:0]  read_x = '0;
    logic [7:0]  read_y = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] pixel_value;

    // Shadow canvas and the quarter-wave sine table the shadow paint uses.
    logic [15:0] canvas_img [SIDE*SIDE];
    longint      quarter_sine [0:90];
    readback_t   readback_q [$];

    int errors = 0;
    int beats_sent = 0;
    int burst_left = 0;
    int stuck_cycles = 0;

    // Receiver stall controls: a requested hold-off and a changing duty.
    int hold_req = 0;
    int hold_left = 0;
    int seg_left = 0;
    int stall_pct = 0;

    rotated_rect_rasterizer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .angle_deg    (angle_deg),
        .rect_width   (rect_width),
        .rect_length  (rect_length),
        .outer_radius (outer_radius),
        .paint_colour (paint_colour),
        .read_x       (read_x),
        .read_y       (read_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_value  (pixel_value)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow arithmetic
    // ------------------------------------------------------------------

    // Fill sin(k deg), k = 0..90, in Q2.14: Taylor series in Q30 up to
    // the x^17 term, then round half up down to 14 fraction bits.
    function automatic void build_quarter_sine();
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint unsigned acc;
        for (int k = 0; k <= 90; k++)
        begin
            ang  = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
            ang2 = (ang * ang) >> 30;
            term = ang;
            acc  = ang;
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * ang2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
                acc  = (n % 2 == 1) ? acc - term : acc + term;
            end
            quarter_sine[k] = longint'((acc + 64'd32768) >> 16);
        end
    endfunction

    // Full-circle sine by quadrant symmetry; angle already below 360.
    function automatic longint sine_of(input int a);
        if (a < 90)
            return quarter_sine[a];
        else if (a < 180)
            return quarter_sine[180 - a];
        else if (a < 270)
            return -quarter_sine[a - 180];
        else
            return -quarter_sine[360 - a];
    endfunction

    // Rotate point (u across, r outward) about the canvas centre and round
    // it half up to a pixel. Arithmetic shift gives a true floor for negatives.
    function automatic void point_pixel(input int ang, input int u, input int r,
                                        output int xi, output int yi);
        longint sa;
        longint ca;
        longint px;
        longint py;
        sa = sine_of(ang % 360);
        ca = sine_of((ang % 360 + 90) % 360);
        px = CENTRE_Q14 + longint'(u) * ca + longint'(r) * sa;
        py = CENTRE_Q14 + longint'(u) * sa - longint'(r) * ca;
        xi = int'((px + HALF_Q14) >>> 14);
        yi = int'((py + HALF_Q14) >>> 14);
    endfunction

    // Apply one paint beat to the shadow canvas; off-canvas points drop.
    function automatic void paint_shadow(input int ang, input int wid, input int len,
                                         input int rad, input logic [15:0] colour);
        int xi;
        int yi;
        for (int v = 0; v < len; v++)
        begin
            for (int u = -(wid / 2); u <= wid / 2; u++)
            begin
                point_pixel(ang, u, rad - v, xi, yi);
                if (xi >= 0 && xi < SIDE && yi >= 0 && yi < SIDE)
                    canvas_img[yi * SIDE + xi] = colour;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Check the out beat
    // first; any read accepted at this same edge cannot answer before the
    // next one, so the order here never matters.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        readback_t want;
        logic      moved;
        moved = 1'b0;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            moved = 1'b1;
            if (readback_q.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected pixel_value %h, expected none",
                             $time, pixel_value);
                errors++;
            end
            else
            begin
                want = readback_q.pop_front();
                if (pixel_value !== want.pixel)
                begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: pixel (%0d,%0d) expected %h, got %h",
                                 $time, want.x, want.y, want.pixel, pixel_value);
                    errors++;
                end
            end
        end
        if (rst_n && in_valid === 1'b1 && in_stall === 1'b0)
        begin
            moved = 1'b1;
            if (action == 1'b0)
            begin
                paint_shadow(int'(angle_deg), int'(rect_width), int'(rect_length),
                             int'(outer_radius), paint_colour);
            end
            else
            begin
                want.x = int'(read_x);
                want.y = int'(read_y);
                want.pixel = (want.x < SIDE && want.y < SIDE)
                             ? canvas_img[want.y * SIDE + want.x] : 16'h0000;
                readback_q.push_back(want);
            end
        end
        stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall duty changes in segments of random length, from
    // none at all to heavy. A hold-off request forces stall for a counted
    // stretch regardless of the duty.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (seg_left == 0)
        begin
            seg_left = $urandom_range(16, 160);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        seg_left--;
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one beat and hold it until accepted. Beats go out in bursts;
    // between bursts drop valid for a random gap, now and then a long one.
    task automatic send_beat(input logic act, input int ang, input int wid,
                             input int len, input int rad, input int col,
                             input int rx, input int ry);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid     <= 1'b1;
        action       <= act;
        angle_deg    <= 9'(ang);
        rect_width   <= 5'(wid);
        rect_length  <= 8'(len);
        outer_radius <= 8'(rad);
        paint_colour <= 16'(col);
        read_x       <= 8'(rx);
        read_y       <= 8'(ry);
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        beats_sent++;
    endtask

    // Paint beat; the unused read fields carry noise.
    task automatic paint_beat(input int ang, input int wid, input int len,
                              input int rad, input int col);
        send_beat(1'b0, ang, wid, len, rad, col, $urandom_range(0, 255),
                  $urandom_range(0, 255));
    endtask

    // Read beat; the unused paint fields carry noise.
    task automatic read_beat(input int rx, input int ry);
        send_beat(1'b1, $urandom_range(0, 359), $urandom_range(0, 31),
                  $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 65535), rx, ry);
    endtask

    // Read back the pixel a given point lands on, optionally nudged by one
    // to probe the rounding edge. Off-canvas points wrap into the canvas.
    task automatic read_point(input int ang, input int u, input int r, input bit nudge);
        int xi;
        int yi;
        point_pixel(ang, u, r, xi, yi);
        if (nudge)
        begin
            xi += int'($urandom_range(0, 2)) - 1;
            yi += int'($urandom_range(0, 2)) - 1;
        end
        read_beat(xi & (SIDE - 1), yi & (SIDE - 1));
    endtask

    // Read a random point of a painted shape, or anywhere if it was empty.
    task automatic read_painted(input int ang, input int wid, input int len, input int rad);
        int v;
        int u;
        if (len == 0)
        begin
            read_beat($urandom_range(0, 255), $urandom_range(0, 255));
        end
        else
        begin
            v = $urandom_range(0, len - 1);
            u = int'($urandom_range(0, 2 * (wid / 2))) - wid / 2;
            read_point(ang, u, rad - v, $urandom_range(0, 3) == 0);
        end
    endtask

    // Drop valid and hold off until every pending read has answered.
    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (readback_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Canvas corners read zero once the clearing pass is done.
    task automatic test_cleared_canvas();
        read_beat(0, 0);
        read_beat(SIDE - 1, SIDE - 1);
        read_beat(0, SIDE - 1);
        read_beat(SIDE - 1, 0);
    endtask

    // Field extremes and each named corner case, each checked by reads.
    task automatic test_directed_paints();
        // Widest and longest, from the maximum radius: rows run in to just short
        // of the centre and many points fall off the canvas.
        paint_beat(0, 31, 255, 255, 16'hFFFF);
        read_point(0, 15, 100, 1'b0);
        read_point(0, -15, -100, 1'b0);
        // Single column at width one, quarter turn.
        paint_beat(90, 1, 40, 60, 16'h8421);
        read_point(90, 0, 60, 1'b0);
        read_point(90, 0, 21, 1'b0);
        // Zero length paints nothing; last angle of the range.
        paint_beat(359, 0, 0, 200, 16'h7BEF);
        read_point(359, 0, 100, 1'b0);
        read_point(359, 0, 120, 1'b0);
        // Short rows through the centre, half turn, even width.
        paint_beat(180, 2, 20, 10, 16'hF800);
        read_point(180, 1, 0, 1'b0);
        read_point(180, -1, -9, 1'b0);
        // Three quarter turn reaching to one pixel from the canvas edge.
        paint_beat(270, 7, 30, 127, 16'h07E0);
        read_point(270, 3, 127, 1'b0);
        read_point(270, -3, 98, 1'b0);
        // Radius zero: every row at or past the centre; colour all zero.
        paint_beat(45, 30, 10, 0, 16'h0000);
        read_point(45, 15, 0, 1'b0);
        read_point(45, -15, -9, 1'b0);
    endtask

    // Long receiver hold-off while reads keep coming: the first result
    // waits on out, the block stalls its input, then everything drains.
    task automatic test_output_backpressure();
        pause_until_drained();
        hold_req = 400;
        repeat (10)
            read_beat($urandom_range(0, 255), $urandom_range(0, 255));
        pause_until_drained();
    endtask

    // Mostly a paint followed by reads of its own pixels; the rest are
    // stray reads. Most paints stay small; one in ten is large.
    task automatic test_random_traffic(input int target);
        int ang;
        int wid;
        int len;
        int rad;
        while (beats_sent < target)
        begin
            ang = $urandom_range(0, 359);
            if ($urandom_range(0, 9) == 0)
            begin
                wid = $urandom_range(0, 31);
                len = $urandom_range(100, 255);
                rad = $urandom_range(0, 255);
            end
            else
            begin
                wid = $urandom_range(0, 12);
                len = $urandom_range(0, 24);
                rad = $urandom_range(0, 180);
            end
            if ($urandom_range(0, 5) != 0)
                paint_beat(ang, wid, len, rad, $urandom_range(0, 65535));
            repeat ($urandom_range(0, 4))
            begin
                if ($urandom_range(0, 3) != 0)
                    read_painted(ang, wid, len, rad);
                else
                    read_beat($urandom_range(0, 255), $urandom_range(0, 255));
            end
            // Now and then let the pipeline run dry before going on.
            if ($urandom_range(0, 39) == 0)
                pause_until_drained();
        end
    endtask

    initial
    begin
        build_quarter_sine();
        foreach (canvas_img[i])
            canvas_img[i] = 16'h0000;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_cleared_canvas();
        test_directed_paints();
        test_output_backpressure();
        test_random_traffic(RANDOM_BEATS);

        // Wait out any paint still in work, then give a stray result time
        // to show up.
        pause_until_drained();
        while (in_stall !== 1'b0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
